FILE: rtl/a2e_pkg.sv
package a2e_pkg;

  // Kind codes of the time string
  localparam logic [1:0] KIND_UTC = 2'd0;  // two-digit year
  localparam logic [1:0] KIND_GEN = 2'd1;  // four-digit year

  // Result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_SHORT     = 2'd1;
  localparam logic [1:0] STATUS_BAD_DIGIT = 2'd2;

  // Character classes
  localparam logic [7:0] CharZero = 8'd48;
  localparam logic [7:0] CharNine = 8'd57;

  // Two-digit fields after the year: month, day, hour, minute, second
  localparam int unsigned FieldCnt   = 5;
  localparam logic [4:0]  FieldChars = 5'd10;

  // Year mapping
  localparam logic [13:0] UtcPivot  = 14'd70;
  localparam logic [13:0] YearUtcLo = 14'd2000;
  localparam logic [13:0] YearBase  = 14'd1900;

  // Calendar arithmetic
  localparam logic [8:0]  YearBias    = 9'd400;      // keep the March-based year positive
  localparam logic [5:0]  MonRecip    = 6'd43;       // floor(x / 12) = (x * 43) >> 9, x < 128
  localparam logic [12:0] Recip100    = 13'd5243;    // floor(x / 100) = (x * 5243) >> 19
  localparam logic [8:0]  DaysPerYear = 9'd365;
  localparam logic [19:0] DayBias     = 20'd865566;  // 719468 + 146097 + 1
  localparam logic [16:0] SecPerDay   = 17'd86400;
  localparam logic [11:0] SecPerHour  = 12'd3600;
  localparam logic [5:0]  SecPerMin   = 6'd60;

  // Queue and pipeline sizes
  localparam int unsigned RecQDepth  = 2;
  localparam int unsigned ResQDepth  = 8;
  localparam int unsigned PipeStages = 5;

  // One parsed string, handed from the front to the back
  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  kind;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
  } rec_t;

  // One finished result
  typedef struct packed {
    logic [1:0]  status;
    logic [38:0] epoch;
  } res_t;

  // Day of the March-based year on which month (index 0 = January) starts
  function automatic logic [8:0] doy_of(input logic [3:0] mon_idx);
    logic [8:0] doy;
    case (mon_idx)
      4'd0:    doy = 9'd306;
      4'd1:    doy = 9'd337;
      4'd2:    doy = 9'd0;
      4'd3:    doy = 9'd31;
      4'd4:    doy = 9'd61;
      4'd5:    doy = 9'd92;
      4'd6:    doy = 9'd122;
      4'd7:    doy = 9'd153;
      4'd8:    doy = 9'd184;
      4'd9:    doy = 9'd214;
      4'd10:   doy = 9'd245;
      4'd11:   doy = 9'd275;
      default: doy = 9'd0;
    endcase
    return doy;
  endfunction

endpackage

FILE: rtl/asn1_time_to_epoch_unit.sv
// Takes one character per cycle; full only rises when the two-entry record queue backs up.
// A result reaches the result ports by way of the record queue, then five stages of calendar
// arithmetic and the result queue; a record waits in its queue while the result queue lacks room.
// Throughput is one string per cycle at most, set by the record queue and 8-entry result queue.
// Reset (asynchronous, active low) clears the parser state and empties both queues.
module asn1_time_to_epoch_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         char_code_i,
  input  logic [1:0]         time_kind_i,
  input  logic               last_char_i,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         status_o,
  output logic signed [38:0] epoch_seconds_o
);

  logic          accept;
  logic          rec_valid;
  a2e_pkg::rec_t rec_front;
  a2e_pkg::rec_t rec_back;
  logic          rec_empty;
  logic          rec_pop;

  assign accept = push && !full;

  a2e_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .char_code_i (char_code_i),
    .time_kind_i (time_kind_i),
    .last_char_i (last_char_i),
    .rec_valid_o (rec_valid),
    .rec_o       (rec_front)
  );

  a2e_rec_queue u_rec_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_valid),
    .rec_i   (rec_front),
    .full_o  (full),
    .pop_i   (rec_pop),
    .empty_o (rec_empty),
    .rec_o   (rec_back)
  );

  a2e_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rec_empty_i     (rec_empty),
    .rec_i           (rec_back),
    .rec_pop_o       (rec_pop),
    .empty_o         (empty),
    .pop_i           (pop),
    .status_o        (status_o),
    .epoch_seconds_o (epoch_seconds_o)
  );

endmodule

FILE: rtl/a2e_front.sv
module a2e_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        char_code_i,
  input  logic [1:0]        time_kind_i,
  input  logic              last_char_i,
  output logic              rec_valid_o,
  output a2e_pkg::rec_t     rec_o
);

  logic [3:0]  pos_q, pos_d;
  logic [1:0]  kind_q, kind_d;
  logic [13:0] year_q, year_d;
  logic [6:0]  fld_q [a2e_pkg::FieldCnt];
  logic [6:0]  fld_d [a2e_pkg::FieldCnt];
  logic        bad_q, bad_d;
  logic        pend_q, pend_d;

  logic [1:0]  kind;
  logic [2:0]  ylen;
  logic        is_dig;
  logic [3:0]  dig;
  logic [6:0]  dig_x10;
  logic        in_year;
  logic        in_fld;
  logic [4:0]  qpos;
  logic [2:0]  fsel;
  logic [4:0]  len;
  logic [4:0]  rem;
  logic [3:0]  pos_nxt;
  logic [13:0] year_nxt;
  logic [6:0]  fld_nxt [a2e_pkg::FieldCnt];
  logic        bad_nxt;
  logic        pend_nxt;

  // Classify the character against the current position
  always_comb begin
    kind = (pos_q == 4'd0) ? time_kind_i : kind_q;
    case (kind)
      a2e_pkg::KIND_UTC: ylen = 3'd2;
      a2e_pkg::KIND_GEN: ylen = 3'd4;
      default:           ylen = 3'd0;
    endcase
    is_dig  = char_code_i inside {[a2e_pkg::CharZero:a2e_pkg::CharNine]};
    dig     = is_dig ? 4'(char_code_i - a2e_pkg::CharZero) : 4'd0;
    dig_x10 = 7'({dig, 3'b000}) + 7'({dig, 1'b0});
    in_year = {1'b0, pos_q} < {2'b00, ylen};
    qpos    = {1'b0, pos_q} - {2'b00, ylen};
    in_fld  = !in_year && (qpos < a2e_pkg::FieldChars);
    fsel    = qpos[3:1];
    pos_nxt = (pos_q == 4'hF) ? pos_q : pos_q + 4'd1;

    // Accumulate the digit into its field
    year_nxt = year_q;
    bad_nxt  = bad_q;
    pend_nxt = pend_q;
    for (int i = 0; i < a2e_pkg::FieldCnt; i++) begin
      fld_nxt[i] = fld_q[i];
    end
    if (in_year) begin
      year_nxt = 14'({year_q, 3'b000}) + 14'({year_q, 1'b0}) + 14'(dig);
      if (!is_dig) begin
        bad_nxt = 1'b1;
      end
    end else if (in_fld) begin
      for (int i = 0; i < a2e_pkg::FieldCnt; i++) begin
        if (fsel == 3'(i)) begin
          fld_nxt[i] = qpos[0] ? fld_q[i] + 7'(dig) : dig_x10;
        end
      end
      // Month and day are checked at once; optional pairs only when complete
      if (fsel < 3'd2) begin
        if (!is_dig) begin
          bad_nxt = 1'b1;
        end
      end else if (!qpos[0]) begin
        pend_nxt = !is_dig;
      end else if (pend_q || !is_dig) begin
        bad_nxt = 1'b1;
      end
    end

    // Build the record for a string that ends here
    len = {1'b0, pos_q} + 5'd1;
    rem = len - {2'b00, ylen};
    if (len < ({2'b00, ylen} + 5'd4)) begin
      rec_o.status = a2e_pkg::STATUS_SHORT;
    end else if (bad_nxt) begin
      rec_o.status = a2e_pkg::STATUS_BAD_DIGIT;
    end else begin
      rec_o.status = a2e_pkg::STATUS_OK;
    end
    rec_o.kind   = kind;
    rec_o.year   = year_nxt;
    rec_o.month  = fld_nxt[0];
    rec_o.day    = fld_nxt[1];
    rec_o.hour   = (rem >= 5'd6)  ? fld_nxt[2] : 7'd0;
    rec_o.minute = (rem >= 5'd8)  ? fld_nxt[3] : 7'd0;
    rec_o.second = (rem >= 5'd10) ? fld_nxt[4] : 7'd0;
    rec_valid_o  = accept_i && last_char_i;

    // Advance on a beat, clear after the last character
    pos_d  = pos_q;
    kind_d = kind_q;
    year_d = year_q;
    bad_d  = bad_q;
    pend_d = pend_q;
    for (int i = 0; i < a2e_pkg::FieldCnt; i++) begin
      fld_d[i] = fld_q[i];
    end
    if (accept_i) begin
      if (last_char_i) begin
        pos_d  = 4'd0;
        kind_d = 2'd0;
        year_d = 14'd0;
        bad_d  = 1'b0;
        pend_d = 1'b0;
        for (int i = 0; i < a2e_pkg::FieldCnt; i++) begin
          fld_d[i] = 7'd0;
        end
      end else begin
        pos_d  = pos_nxt;
        kind_d = kind;
        year_d = year_nxt;
        bad_d  = bad_nxt;
        pend_d = pend_nxt;
        for (int i = 0; i < a2e_pkg::FieldCnt; i++) begin
          fld_d[i] = fld_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= 4'd0;
      kind_q <= 2'd0;
      year_q <= 14'd0;
      bad_q  <= 1'b0;
      pend_q <= 1'b0;
      for (int i = 0; i < a2e_pkg::FieldCnt; i++) begin
        fld_q[i] <= 7'd0;
      end
    end else begin
      pos_q  <= pos_d;
      kind_q <= kind_d;
      year_q <= year_d;
      bad_q  <= bad_d;
      pend_q <= pend_d;
      for (int i = 0; i < a2e_pkg::FieldCnt; i++) begin
        fld_q[i] <= fld_d[i];
      end
    end
  end

endmodule

FILE: rtl/a2e_rec_queue.sv
module a2e_rec_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  a2e_pkg::rec_t     rec_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output a2e_pkg::rec_t     rec_o
);

  localparam int unsigned PtrW = $clog2(a2e_pkg::RecQDepth);
  localparam int unsigned CntW = $clog2(a2e_pkg::RecQDepth + 1);

  a2e_pkg::rec_t   mem_q [a2e_pkg::RecQDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  // Move pointers and fill count
  always_comb begin
    full_o   = cnt_q == CntW'(a2e_pkg::RecQDepth);
    empty_o  = cnt_q == '0;
    do_push  = push_i && !full_o;
    do_pop   = pop_i && !empty_o;
    rec_o    = mem_q[rd_ptr_q];
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(a2e_pkg::RecQDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(a2e_pkg::RecQDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the pushed record
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

endmodule

FILE: rtl/a2e_back.sv
module a2e_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rec_empty_i,
  input  a2e_pkg::rec_t      rec_i,
  output logic               rec_pop_o,
  output logic               empty_o,
  input  logic               pop_i,
  output logic [1:0]         status_o,
  output logic signed [38:0] epoch_seconds_o
);

  localparam int unsigned OutPtrW = $clog2(a2e_pkg::ResQDepth);
  localparam int unsigned OutCntW = $clog2(a2e_pkg::ResQDepth + 1);
  localparam int unsigned FlightW = $clog2(a2e_pkg::PipeStages + 1);

  logic [a2e_pkg::PipeStages-1:0] vld_q;
  logic [FlightW-1:0]             inflight;

  // Stage 1: mapped year
  logic [1:0]  s1_status_q;
  logic [13:0] s1_yb_q;
  logic [6:0]  s1_month_q, s1_day_q, s1_hour_q, s1_min_q, s1_sec_q;
  logic [13:0] yb;

  // Stage 2: March-based year and day of year
  logic [1:0]  s2_status_q;
  logic [13:0] s2_yy_q;
  logic [8:0]  s2_doy_q;
  logic [6:0]  s2_day_q, s2_hour_q, s2_min_q, s2_sec_q;
  logic [6:0]  mm1;
  logic [12:0] qprod;
  logic [3:0]  q_yr;
  logic [3:0]  mon_idx;
  logic [13:0] yy;

  // Stage 3: products
  logic [1:0]  s3_status_q;
  logic [21:0] s3_y365_q;
  logic [11:0] s3_yq4_q;
  logic [7:0]  s3_c100_q;
  logic [5:0]  s3_c400_q;
  logic [8:0]  s3_doy_q;
  logic [6:0]  s3_day_q;
  logic [18:0] s3_hms_q;
  logic [26:0] p100;
  logic [24:0] p400;

  // Stage 4: day count
  logic [1:0]  s4_status_q;
  logic [24:0] s4_days_q;
  logic [18:0] s4_hms_q;
  logic [24:0] days;

  // Stage 5: day count in seconds
  logic [1:0]         s5_status_q;
  logic signed [38:0] s5_prod_q;
  logic [18:0]        s5_hms_q;
  logic signed [38:0] prod;

  // Result queue
  a2e_pkg::res_t      res_mem_q [a2e_pkg::ResQDepth];
  a2e_pkg::res_t      res_new;
  logic [OutPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [OutCntW-1:0] cnt_q;
  logic               res_push;
  logic               res_pop;

  // Issue a record only when the result queue has room for everything in flight
  always_comb begin
    inflight  = FlightW'($countones(vld_q));
    rec_pop_o = !rec_empty_i &&
                ((OutCntW + 1)'(cnt_q) + (OutCntW + 1)'(inflight)
                 < (OutCntW + 1)'(a2e_pkg::ResQDepth));
  end

  // Map the year field by kind
  always_comb begin
    case (rec_i.kind)
      a2e_pkg::KIND_UTC: yb = rec_i.year + ((rec_i.year < a2e_pkg::UtcPivot) ?
                                            a2e_pkg::YearUtcLo : a2e_pkg::YearBase);
      a2e_pkg::KIND_GEN: yb = rec_i.year;
      default:           yb = a2e_pkg::YearBase;
    endcase
  end

  // Fold the month into an index 0..11 (0 = January) and shift the year to start in March
  always_comb begin
    mm1   = s1_month_q - 7'd1;
    qprod = 13'(mm1) * 13'(a2e_pkg::MonRecip);
    if (s1_month_q == 7'd0) begin
      q_yr    = 4'd0;
      mon_idx = 4'd11;
    end else begin
      q_yr    = qprod[12:9];
      mon_idx = 4'(mm1 - 7'({q_yr, 3'b000}) - 7'({q_yr, 2'b00}));
    end
    yy = 14'(15'(s1_yb_q) + 15'(a2e_pkg::YearBias) + 15'(q_yr)
             - 15'(s1_month_q == 7'd0) - 15'(mon_idx < 4'd2));
  end

  // Scale the year for the leap-day terms
  always_comb begin
    p100 = 27'(s2_yy_q) * 27'(a2e_pkg::Recip100);
    p400 = 25'(s2_yy_q[13:2]) * 25'(a2e_pkg::Recip100);
  end

  // Sum the day count, then turn it into seconds
  always_comb begin
    days = 25'(s3_y365_q) + 25'(s3_yq4_q) - 25'(s3_c100_q) + 25'(s3_c400_q)
           + 25'(s3_doy_q) + 25'(s3_day_q) - 25'(a2e_pkg::DayBias);
    prod = $signed(s4_days_q) * $signed({1'b0, a2e_pkg::SecPerDay});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[a2e_pkg::PipeStages-2:0], rec_pop_o};
    end
  end

  // Advance the payload every cycle
  always_ff @(posedge clk_i) begin
    s1_status_q <= rec_i.status;
    s1_yb_q     <= yb;
    s1_month_q  <= rec_i.month;
    s1_day_q    <= rec_i.day;
    s1_hour_q   <= rec_i.hour;
    s1_min_q    <= rec_i.minute;
    s1_sec_q    <= rec_i.second;

    s2_status_q <= s1_status_q;
    s2_yy_q     <= yy;
    s2_doy_q    <= a2e_pkg::doy_of(mon_idx);
    s2_day_q    <= s1_day_q;
    s2_hour_q   <= s1_hour_q;
    s2_min_q    <= s1_min_q;
    s2_sec_q    <= s1_sec_q;

    s3_status_q <= s2_status_q;
    s3_y365_q   <= 22'(s2_yy_q) * 22'(a2e_pkg::DaysPerYear);
    s3_yq4_q    <= s2_yy_q[13:2];
    s3_c100_q   <= p100[26:19];
    s3_c400_q   <= p400[24:19];
    s3_doy_q    <= s2_doy_q;
    s3_day_q    <= s2_day_q;
    s3_hms_q    <= 19'(s2_hour_q) * 19'(a2e_pkg::SecPerHour)
                   + 19'(s2_min_q) * 19'(a2e_pkg::SecPerMin) + 19'(s2_sec_q);

    s4_status_q <= s3_status_q;
    s4_days_q   <= days;
    s4_hms_q    <= s3_hms_q;

    s5_status_q <= s4_status_q;
    s5_prod_q   <= prod;
    s5_hms_q    <= s4_hms_q;
  end

  // Drop the epoch for any failed string
  always_comb begin
    res_new.status = s5_status_q;
    res_new.epoch  = (s5_status_q == a2e_pkg::STATUS_OK) ?
                     39'(s5_prod_q + $signed({20'd0, s5_hms_q})) : 39'd0;
    res_push       = vld_q[a2e_pkg::PipeStages-1];
    empty_o        = cnt_q == '0;
    res_pop        = pop_i && !empty_o;
    status_o        = res_mem_q[rd_ptr_q].status;
    epoch_seconds_o = $signed(res_mem_q[rd_ptr_q].epoch);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (res_push) begin
        wr_ptr_q <= (wr_ptr_q == OutPtrW'(a2e_pkg::ResQDepth - 1)) ? '0
                    : wr_ptr_q + OutPtrW'(1);
      end
      if (res_pop) begin
        rd_ptr_q <= (rd_ptr_q == OutPtrW'(a2e_pkg::ResQDepth - 1)) ? '0
                    : rd_ptr_q + OutPtrW'(1);
      end
      if (res_push && !res_pop) begin
        cnt_q <= cnt_q + OutCntW'(1);
      end else if (res_pop && !res_push) begin
        cnt_q <= cnt_q - OutCntW'(1);
      end
    end
  end

  // Hold finished results until popped
  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_mem_q[wr_ptr_q] <= res_new;
    end
  end

endmodule
